>>> src/u8cp_pkg.sv
// package for the utf-8 to cp1250 transcoder: types, kinds, lookup table
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package u8cp_pkg;

  typedef enum logic [1:0] {
    KIND_ASCII = 2'd0,
    KIND_MAPPED = 2'd1,
    KIND_REPL = 2'd2,
    KIND_RAW = 2'd3
  } kind_t;

  localparam int MAX_OUT = 4;
  localparam int QDEPTH = 2;
  localparam logic [7:0] REPL_RESET = 8'h3F;

  // one decoded transaction handed from front to back
  typedef struct packed {
    logic [2:0]  n_raw;     // raw bytes to emit first (0..4)
    logic [31:0] raw_bytes; // raw bytes, first in [7:0]
    logic        has_tail;  // a final byte follows the raw bytes
    logic [7:0]  tail_byte;
    kind_t       tail_kind;
    logic [20:0] cp;        // code point for table lookup
    logic        lookup;    // tail comes from table/replacement
  } item_t;

  // cp1250 upper-half map; returns hit flag and byte
  function automatic logic [8:0] cp_lookup(input logic [20:0] cp);
    logic [8:0] r;
    r = 9'd0;
    unique case (cp)
      21'h20AC: r = {1'b1, 8'h80}; 21'h201A: r = {1'b1, 8'h82};
      21'h201E: r = {1'b1, 8'h84}; 21'h2026: r = {1'b1, 8'h85};
      21'h2020: r = {1'b1, 8'h86}; 21'h2021: r = {1'b1, 8'h87};
      21'h2030: r = {1'b1, 8'h89}; 21'h0160: r = {1'b1, 8'h8A};
      21'h2039: r = {1'b1, 8'h8B}; 21'h015A: r = {1'b1, 8'h8C};
      21'h0164: r = {1'b1, 8'h8D}; 21'h017D: r = {1'b1, 8'h8E};
      21'h0179: r = {1'b1, 8'h8F}; 21'h2018: r = {1'b1, 8'h91};
      21'h2019: r = {1'b1, 8'h92}; 21'h201C: r = {1'b1, 8'h93};
      21'h201D: r = {1'b1, 8'h94}; 21'h2022: r = {1'b1, 8'h95};
      21'h2013: r = {1'b1, 8'h96}; 21'h2014: r = {1'b1, 8'h97};
      21'h2122: r = {1'b1, 8'h99}; 21'h0161: r = {1'b1, 8'h9A};
      21'h203A: r = {1'b1, 8'h9B}; 21'h015B: r = {1'b1, 8'h9C};
      21'h0165: r = {1'b1, 8'h9D}; 21'h017E: r = {1'b1, 8'h9E};
      21'h017A: r = {1'b1, 8'h9F}; 21'h00A0: r = {1'b1, 8'hA0};
      21'h02C7: r = {1'b1, 8'hA1}; 21'h02D8: r = {1'b1, 8'hA2};
      21'h0141: r = {1'b1, 8'hA3}; 21'h00A4: r = {1'b1, 8'hA4};
      21'h0104: r = {1'b1, 8'hA5}; 21'h00A6: r = {1'b1, 8'hA6};
      21'h00A7: r = {1'b1, 8'hA7}; 21'h00A8: r = {1'b1, 8'hA8};
      21'h00A9: r = {1'b1, 8'hA9}; 21'h015E: r = {1'b1, 8'hAA};
      21'h00AB: r = {1'b1, 8'hAB}; 21'h00AC: r = {1'b1, 8'hAC};
      21'h00AD: r = {1'b1, 8'hAD}; 21'h00AE: r = {1'b1, 8'hAE};
      21'h017B: r = {1'b1, 8'hAF}; 21'h00B0: r = {1'b1, 8'hB0};
      21'h00B1: r = {1'b1, 8'hB1}; 21'h02DB: r = {1'b1, 8'hB2};
      21'h0142: r = {1'b1, 8'hB3}; 21'h00B4: r = {1'b1, 8'hB4};
      21'h00B5: r = {1'b1, 8'hB5}; 21'h00B6: r = {1'b1, 8'hB6};
      21'h00B7: r = {1'b1, 8'hB7}; 21'h00B8: r = {1'b1, 8'hB8};
      21'h0105: r = {1'b1, 8'hB9}; 21'h015F: r = {1'b1, 8'hBA};
      21'h00BB: r = {1'b1, 8'hBB}; 21'h013D: r = {1'b1, 8'hBC};
      21'h02DD: r = {1'b1, 8'hBD}; 21'h013E: r = {1'b1, 8'hBE};
      21'h017C: r = {1'b1, 8'hBF}; 21'h0154: r = {1'b1, 8'hC0};
      21'h00C1: r = {1'b1, 8'hC1}; 21'h00C2: r = {1'b1, 8'hC2};
      21'h0102: r = {1'b1, 8'hC3}; 21'h00C4: r = {1'b1, 8'hC4};
      21'h0139: r = {1'b1, 8'hC5}; 21'h0106: r = {1'b1, 8'hC6};
      21'h00C7: r = {1'b1, 8'hC7}; 21'h010C: r = {1'b1, 8'hC8};
      21'h00C9: r = {1'b1, 8'hC9}; 21'h0118: r = {1'b1, 8'hCA};
      21'h00CB: r = {1'b1, 8'hCB}; 21'h011A: r = {1'b1, 8'hCC};
      21'h00CD: r = {1'b1, 8'hCD}; 21'h00CE: r = {1'b1, 8'hCE};
      21'h010E: r = {1'b1, 8'hCF}; 21'h0110: r = {1'b1, 8'hD0};
      21'h0143: r = {1'b1, 8'hD1}; 21'h0147: r = {1'b1, 8'hD2};
      21'h00D3: r = {1'b1, 8'hD3}; 21'h00D4: r = {1'b1, 8'hD4};
      21'h0150: r = {1'b1, 8'hD5}; 21'h00D6: r = {1'b1, 8'hD6};
      21'h00D7: r = {1'b1, 8'hD7}; 21'h0158: r = {1'b1, 8'hD8};
      21'h016E: r = {1'b1, 8'hD9}; 21'h00DA: r = {1'b1, 8'hDA};
      21'h0170: r = {1'b1, 8'hDB}; 21'h00DC: r = {1'b1, 8'hDC};
      21'h00DD: r = {1'b1, 8'hDD}; 21'h0162: r = {1'b1, 8'hDE};
      21'h00DF: r = {1'b1, 8'hDF}; 21'h0155: r = {1'b1, 8'hE0};
      21'h00E1: r = {1'b1, 8'hE1}; 21'h00E2: r = {1'b1, 8'hE2};
      21'h0103: r = {1'b1, 8'hE3}; 21'h00E4: r = {1'b1, 8'hE4};
      21'h013A: r = {1'b1, 8'hE5}; 21'h0107: r = {1'b1, 8'hE6};
      21'h00E7: r = {1'b1, 8'hE7}; 21'h010D: r = {1'b1, 8'hE8};
      21'h00E9: r = {1'b1, 8'hE9}; 21'h0119: r = {1'b1, 8'hEA};
      21'h00EB: r = {1'b1, 8'hEB}; 21'h011B: r = {1'b1, 8'hEC};
      21'h00ED: r = {1'b1, 8'hED}; 21'h00EE: r = {1'b1, 8'hEE};
      21'h010F: r = {1'b1, 8'hEF}; 21'h0111: r = {1'b1, 8'hF0};
      21'h0144: r = {1'b1, 8'hF1}; 21'h0148: r = {1'b1, 8'hF2};
      21'h00F3: r = {1'b1, 8'hF3}; 21'h00F4: r = {1'b1, 8'hF4};
      21'h0151: r = {1'b1, 8'hF5}; 21'h00F6: r = {1'b1, 8'hF6};
      21'h00F7: r = {1'b1, 8'hF7}; 21'h0159: r = {1'b1, 8'hF8};
      21'h016F: r = {1'b1, 8'hF9}; 21'h00FA: r = {1'b1, 8'hFA};
      21'h0171: r = {1'b1, 8'hFB}; 21'h00FC: r = {1'b1, 8'hFC};
      21'h00FD: r = {1'b1, 8'hFD}; 21'h0163: r = {1'b1, 8'hFE};
      21'h02D9: r = {1'b1, 8'hFF};
      default:  r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> src/utf8_to_cp1250_transcoder_top.sv
// utf-8 to cp1250 transcoder: one byte per cycle in and one out, unless in_stall/out_stall
// front is combinational; items are registered in the queue, then in the output register
// throughput: one transaction per cycle when it yields at most one byte, unless stalled;
//   a transaction yielding more holds the output until all its bytes leave the single port
// reset: synchronous active-low rst_n clears sequence state, queue, output; replacement 0x3F
// depends on u8cp_pkg, u8cp_front, u8cp_queue, u8cp_back
`timescale 1ns / 1ps
`default_nettype none
module utf8_to_cp1250_transcoder_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_end_of_stream,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       out_byte,
  output logic [1:0]       out_kind,
  output logic             out_run_last,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [1:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import u8cp_pkg::*;

  item_t      f_item, q_item;
  logic       f_valid, f_stall, q_valid, q_pop;
  logic [7:0] repl_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == 2'd0) ? {24'd0, repl_r} : 32'd0;

  // replacement register
  always_ff @(posedge clk) begin
    if (!rst_n) repl_r <= REPL_RESET;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == 2'd0)
      repl_r <= cfg_pwdata[7:0];
  end

  u8cp_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_byte, .in_end_of_stream,
    .item_valid(f_valid), .item_stall(f_stall), .item(f_item)
  );

  u8cp_queue u_queue (
    .clk, .rst_n, .wr_valid(f_valid), .wr_stall(f_stall), .wr_item(f_item),
    .rd_valid(q_valid), .rd_pop(q_pop), .rd_item(q_item)
  );

  u8cp_back u_back (
    .clk, .rst_n, .q_valid, .q_pop, .q_item, .repl_byte(repl_r),
    .out_valid, .out_stall, .out_byte, .out_kind, .out_run_last
  );

endmodule
`default_nettype wire

>>> src/u8cp_front.sv
// front end: accepts source bytes, tracks pending sequence, classifies output
// depends on u8cp_pkg
`timescale 1ns / 1ps
`default_nettype none
module u8cp_front (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_stall,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_end_of_stream,
  output logic                 item_valid,
  input  wire logic            item_stall,
  output u8cp_pkg::item_t      item
);
  import u8cp_pkg::*;

  logic [7:0]  held_r [3];
  logic [7:0]  held_nxt [3];
  logic [1:0]  cnt_r, cnt_nxt;
  logic [2:0]  len_r, len_nxt;
  logic [20:0] acc_r, acc_nxt;
  logic [20:0] acc_new;
  logic [20:0] lo;
  item_t       it;
  logic        is_cont, bad;
  logic [2:0]  slen;
  logic [20:0] sbits;

  assign in_stall   = item_stall;
  assign item_valid = in_valid;
  assign item       = it;
  assign is_cont    = (in_byte[7:6] == 2'b10);
  assign acc_new    = {acc_r[14:0], in_byte[5:0]};

  // lead byte class
  always_comb begin
    slen  = 3'd0;
    sbits = 21'd0;
    priority if (in_byte[7:5] == 3'b110) begin
      slen = 3'd2; sbits = {16'd0, in_byte[4:0]};
    end else if (in_byte[7:4] == 4'b1110) begin
      slen = 3'd3; sbits = {17'd0, in_byte[3:0]};
    end else if (in_byte[7:3] == 5'b11110) begin
      slen = 3'd4; sbits = {18'd0, in_byte[2:0]};
    end else begin
      slen = 3'd0;
    end
  end

  always_comb begin
    lo = (len_r == 3'd2) ? 21'h80 : ((len_r == 3'd3) ? 21'h800 : 21'h10000);
    bad = (acc_new < lo) || (acc_new > 21'h10FFFF) ||
          ((acc_new >= 21'hD800) && (acc_new <= 21'hDFFF));
  end

  // classify the transaction and update sequence state
  always_comb begin
    held_nxt     = held_r;
    cnt_nxt      = cnt_r;
    len_nxt      = len_r;
    acc_nxt      = acc_r;
    it           = '0;
    it.tail_kind = KIND_RAW;
    if ((cnt_r != 2'd0) && is_cont) begin
      if ({1'b0, cnt_r} + 3'd1 >= len_r) begin
        cnt_nxt = 2'd0; len_nxt = 3'd0; acc_nxt = 21'd0;
        if (bad) begin
          it.n_raw     = {1'b0, cnt_r} + 3'd1;
          it.raw_bytes = {8'd0, held_r[2], held_r[1], held_r[0]};
          it.raw_bytes[{cnt_r, 3'b000} +: 8] = in_byte;
        end else begin
          it.has_tail = 1'b1;
          it.lookup   = 1'b1;
          it.cp       = acc_new;
        end
      end else if (in_end_of_stream || cnt_r == 2'd3) begin
        cnt_nxt = 2'd0; len_nxt = 3'd0; acc_nxt = 21'd0;
        it.n_raw     = {1'b0, cnt_r} + 3'd1;
        it.raw_bytes = {8'd0, held_r[2], held_r[1], held_r[0]};
        it.raw_bytes[{cnt_r, 3'b000} +: 8] = in_byte;
      end else begin
        held_nxt[cnt_r] = in_byte;
        cnt_nxt = cnt_r + 2'd1;
        acc_nxt = acc_new;
      end
    end else begin
      // flush whatever is pending, then start fresh
      it.n_raw     = {1'b0, cnt_r};
      it.raw_bytes = {8'd0, held_r[2], held_r[1], held_r[0]};
      cnt_nxt = 2'd0; len_nxt = 3'd0; acc_nxt = 21'd0;
      if (!in_byte[7]) begin
        it.has_tail  = 1'b1;
        it.tail_byte = in_byte;
        it.tail_kind = KIND_ASCII;
      end else if (slen == 3'd0 || in_end_of_stream) begin
        it.has_tail  = 1'b1;
        it.tail_byte = in_byte;
        it.tail_kind = KIND_RAW;
      end else begin
        held_nxt[0] = in_byte;
        cnt_nxt = 2'd1; len_nxt = slen; acc_nxt = sbits;
      end
    end
  end

  // sequence state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      len_r <= 3'd0;
      acc_r <= 21'd0;
      held_r <= '{default: 8'd0};
    end else if (in_valid && !item_stall) begin
      cnt_r <= cnt_nxt;
      len_r <= len_nxt;
      acc_r <= acc_nxt;
      held_r <= held_nxt;
    end
  end

endmodule
`default_nettype wire

>>> src/u8cp_queue.sv
// short fifo of classified transactions between front and back
// depends on u8cp_pkg
`timescale 1ns / 1ps
`default_nettype none
module u8cp_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            wr_valid,
  output logic                 wr_stall,
  input  wire u8cp_pkg::item_t wr_item,
  output logic                 rd_valid,
  input  wire logic            rd_pop,
  output u8cp_pkg::item_t      rd_item
);
  import u8cp_pkg::*;

  item_t      mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign wr_stall = (cnt_r == 2'(QDEPTH));
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_item  = mem_r[rp_r];
  assign push     = wr_valid && !wr_stall;
  assign pop      = rd_pop && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= wr_item;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

>>> src/u8cp_back.sv
// back end: table lookup and serialization of up to four result bytes
// depends on u8cp_pkg
`timescale 1ns / 1ps
`default_nettype none
module u8cp_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            q_valid,
  output logic                 q_pop,
  input  wire u8cp_pkg::item_t q_item,
  input  wire logic [7:0]      repl_byte,
  output logic                 out_valid,
  input  wire logic            out_stall,
  output logic [7:0]           out_byte,
  output logic [1:0]           out_kind,
  output logic                 out_run_last
);
  import u8cp_pkg::*;

  logic [2:0] idx_r, idx_nxt;
  logic [2:0] total;
  logic [8:0] hit;
  logic       vld_r, vld_nxt;
  logic [7:0] byte_r, byte_nxt;
  kind_t      kind_r, kind_nxt;
  logic       last_r, last_nxt;
  logic       load, is_last;

  assign out_valid    = vld_r;
  assign out_byte     = byte_r;
  assign out_kind     = kind_r;
  assign out_run_last = last_r;
  assign total        = q_item.n_raw + {2'd0, q_item.has_tail};
  assign hit          = cp_lookup(q_item.cp);
  assign load         = !vld_r || !out_stall;

  // pick the next result of the head transaction
  always_comb begin
    idx_nxt  = idx_r;
    vld_nxt  = vld_r && out_stall;
    byte_nxt = byte_r;
    kind_nxt = kind_r;
    last_nxt = last_r;
    q_pop    = 1'b0;
    is_last  = (idx_r + 3'd1 >= total);
    if (load && q_valid) begin
      if (total == 3'd0) begin
        q_pop = 1'b1;
      end else begin
        vld_nxt  = 1'b1;
        last_nxt = is_last;
        if (idx_r < q_item.n_raw) begin
          byte_nxt = q_item.raw_bytes[{idx_r[1:0], 3'b000} +: 8];
          kind_nxt = KIND_RAW;
        end else if (q_item.lookup) begin
          byte_nxt = hit[8] ? hit[7:0] : repl_byte;
          kind_nxt = hit[8] ? KIND_MAPPED : KIND_REPL;
        end else begin
          byte_nxt = q_item.tail_byte;
          kind_nxt = q_item.tail_kind;
        end
        if (is_last) begin
          q_pop   = 1'b1;
          idx_nxt = 3'd0;
        end else begin
          idx_nxt = idx_r + 3'd1;
        end
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= 3'd0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    kind_r <= kind_nxt;
    last_r <= last_nxt;
  end

endmodule
`default_nettype wire
